// ===== rtl/pipq_pkg.sv =====
// Package: shared types and constants for the positional insertion queue pair.
`default_nettype none
package pipq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int IW   = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int PW   = 7;
  localparam int CMPW = (CW > PW) ? CW : PW;
  localparam int GSZ  = 8;
  localparam int NGRP = (QUEUE_DEPTH + GSZ - 1) / GSZ;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;

  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_DROP   = 3'd2,
    MODE_MOVE   = 3'd3,
    MODE_READ   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_LOAD = 2'd1,
    S_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [6:0]         position;
    logic               queue_pick;
    logic [31:0]        entry_tag;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         waiting_size;
    logic [6:0]         accepted_size;
    logic [31:0]        read_tag;
    logic signed [31:0] read_first;
    logic signed [31:0] read_second;
  } rsp_t;

  typedef struct packed {
    logic [31:0]        tag;
    logic signed [31:0] first;
    logic signed [31:0] second;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic read_issue;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/pipq_ctrl.sv =====
// Controller: sequences latch, read and commit of one request.
`default_nettype none
module pipq_ctrl
  import pipq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.read_issue = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/pipq_dp.sv =====
// Datapath: waiting shift cells, accepted memory, read tree and result register.
`default_nettype none
module pipq_dp
  import pipq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  output sts_t      sts,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  req_t             req_q;
  entry_t           cells [QUEUE_DEPTH];
  entry_t           acc_mem [QUEUE_DEPTH];
  entry_t           acc_rd;
  entry_t           grp_q [NGRP];
  logic [CW-1:0]    wcnt, wcnt_next;
  logic [CW-1:0]    acnt, acnt_next;
  logic [CMPW-1:0]  pos_ext, wcnt_ext, acnt_ext;
  logic [CW-1:0]    ins;
  logic [GW-1:0]    gidx;
  logic             do_ins, do_pop, do_push;
  status_t          st;
  entry_t           rd_ent, new_ent;

  assign pos_ext  = CMPW'(req_q.position);
  assign wcnt_ext = CMPW'(wcnt);
  assign acnt_ext = CMPW'(acnt);
  assign gidx     = GW'(req_q.position >> 3);
  assign new_ent  = '{tag: req_q.entry_tag, first: req_q.first_value,
                      second: req_q.second_value};
  assign sts.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= req;
    end
  end

  // first level of the read tree: one entry out of each group of eight, plus the accepted memory read
  always_ff @(posedge clk) begin
    if (cmd.read_issue) begin
      for (int g = 0; g < NGRP; g++) begin
        if (g * GSZ + int'(req_q.position[2:0]) < QUEUE_DEPTH) begin
          grp_q[g] <= cells[g * GSZ + int'(req_q.position[2:0])];
        end else begin
          grp_q[g] <= '0;
        end
      end
      acc_rd <= acc_mem[req_q.position[IW-1:0]];
    end
  end

  always_comb begin
    st        = ST_OK;
    rd_ent    = '0;
    wcnt_next = wcnt;
    acnt_next = acnt;
    do_ins    = 1'b0;
    do_pop    = 1'b0;
    do_push   = 1'b0;
    ins       = wcnt;
    if (req_q.mode == MODE_INSERT && pos_ext <= wcnt_ext) begin
      ins = CW'(pos_ext);
    end
    unique case (req_q.mode)
      MODE_INSERT, MODE_APPEND: begin
        if (wcnt == CW'(QUEUE_DEPTH)) begin
          st = ST_FULL;
        end else begin
          do_ins    = 1'b1;
          wcnt_next = wcnt + 1'b1;
        end
      end
      MODE_DROP: begin
        if (wcnt == '0) begin
          st = ST_EMPTY;
        end else begin
          rd_ent    = cells[0];
          do_pop    = 1'b1;
          wcnt_next = wcnt - 1'b1;
        end
      end
      MODE_MOVE: begin
        if (wcnt == '0) begin
          st = ST_EMPTY;
        end else if (acnt == CW'(QUEUE_DEPTH)) begin
          st = ST_FULL;
        end else begin
          rd_ent    = cells[0];
          do_pop    = 1'b1;
          do_push   = 1'b1;
          wcnt_next = wcnt - 1'b1;
          acnt_next = acnt + 1'b1;
        end
      end
      MODE_READ: begin
        if (!req_q.queue_pick) begin
          if (pos_ext >= wcnt_ext) st = ST_RANGE;
          else rd_ent = grp_q[gidx];
        end else begin
          if (pos_ext >= acnt_ext) st = ST_RANGE;
          else rd_ent = acc_rd;
        end
      end
      default: st = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (do_ins) begin
          if (CW'(i) == ins) begin
            cells[i] <= new_ent;
          end else if (i > 0 && CW'(i) > ins) begin
            cells[i] <= cells[(i > 0) ? i - 1 : 0];
          end
        end else if (do_pop && i < QUEUE_DEPTH - 1) begin
          cells[i] <= cells[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && do_push) begin
      acc_mem[acnt[IW-1:0]] <= cells[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt      <= '0;
      acnt      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        wcnt      <= wcnt_next;
        acnt      <= acnt_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.status        <= st;
      rsp.waiting_size  <= 7'(wcnt_next);
      rsp.accepted_size <= 7'(acnt_next);
      rsp.read_tag      <= rd_ent.tag;
      rsp.read_first    <= rd_ent.first;
      rsp.read_second   <= rd_ent.second;
    end
  end

  a_wcnt_bound: assert property (@(posedge clk) disable iff (rst)
    wcnt <= CW'(QUEUE_DEPTH)) else $error("waiting count over depth");
  a_acnt_bound: assert property (@(posedge clk) disable iff (rst)
    acnt <= CW'(QUEUE_DEPTH)) else $error("accepted count over depth");
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid) else $error("commit without result");
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp_valid || rsp_ready)) else $error("result overwritten");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && do_push) |=> acnt == $past(acnt) + 1'b1)
    else $error("move did not bump accepted count");

endmodule
`default_nettype wire

// ===== rtl/positional_insert_queue_pair.sv =====
// Positional insertion queue pair: waiting queue with positional insert, accepted queue.
//
// Requests come in on req (req_valid/req_ready), one result per request leaves on
// rsp (rsp_valid/rsp_ready). Modes: insert at position (clamped to the waiting
// count), append, drop waiting head, move waiting head to the accepted tail, and
// read one entry of either queue. Every result carries status and both counts.
// The waiting queue is a row of shift cells that shift at once, from the insert slot
// up on insert or all on removal; the accepted queue is a memory written at its tail.
// A request is latched at the accepting edge, read in the next cycle (first level
// of the waiting read tree and the accepted memory read port), then committed
// into the result register; no new request is taken until that commit is done.
// req_ready is high whenever the controller is idle, also while a result still
// waits in the output register; commit waits while the receiver stalls and that
// register is still full.
// Reset (rst, synchronous) empties both queues and drops any pending result;
// entry contents are not cleared and are never visible past the counts.
`default_nettype none
module positional_insert_queue_pair
  import pipq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  cmd_t cmd;
  sts_t sts;

  pipq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pipq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
